// ----- rtl/core/csv_field_splitter_trimmed_defines.svh -----
// ---------------------------------------------------------------------------
// csv_field_splitter_trimmed_defines.svh
// Assertion macros shared by the field splitter modules.
// ---------------------------------------------------------------------------
`ifndef CSV_FIELD_SPLITTER_TRIMMED_DEFINES_SVH
`define CSV_FIELD_SPLITTER_TRIMMED_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define CSVFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define CSVFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/csvfs_pkg.sv -----
// ---------------------------------------------------------------------------
// csvfs_pkg
// Types and constants shared by the CSV field splitter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package csvfs_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam int SPACE_DEPTH_DEF = 15;
  // Flush count field covers the largest legal buffer depth (63)
  localparam int CNT_W = 6;
  localparam int CMDQ_DEPTH = 4;

  // One command from the front to the back: a content byte preceded by
  // flush buffered whitespace words, or a field marker.
  typedef struct packed {
    logic [7:0]       data;
    logic             marker;
    logic             row_end;
    logic             ovf;
    logic [CNT_W-1:0] flush;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND,
    BK_LAST
  } back_state_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = c inside {8'd32, [8'd9:8'd13]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/csvfs_ram.sv -----
// ---------------------------------------------------------------------------
// csvfs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module csvfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 15,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/csvfs_queue.sv -----
// ---------------------------------------------------------------------------
// csvfs_queue
// Short command queue between the front and back of the splitter.
// ---------------------------------------------------------------------------
`default_nettype none

module csvfs_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire csvfs_pkg::cmd_t wdata,
  output logic                 full,
  input  wire logic            pop,
  output csvfs_pkg::cmd_t      rdata,
  output logic                 empty
);

  localparam int PW = $clog2(csvfs_pkg::CMDQ_DEPTH);
  localparam int NW = $clog2(csvfs_pkg::CMDQ_DEPTH + 1);

  csvfs_pkg::cmd_t slot_r [csvfs_pkg::CMDQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == NW'(csvfs_pkg::CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + NW'(do_push) - NW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/csvfs_front.sv -----
// ---------------------------------------------------------------------------
// csvfs_front
// Accepts line bytes, resolves quoting and whitespace, and issues commands.
// ---------------------------------------------------------------------------
`default_nettype none

`include "csv_field_splitter_trimmed_defines.svh"

module csvfs_front #(
  parameter int SPACE_DEPTH = csvfs_pkg::SPACE_DEPTH_DEF,
  parameter int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    in_char_byte,
  input  wire logic          in_line_end,
  input  wire logic          in_push,
  output logic               in_full,
  output logic               q_push,
  output csvfs_pkg::cmd_t    q_cmd,
  input  wire logic          q_full,
  input  wire logic          flush_done,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [7:0]         ram_wdata
);

  localparam int CW = $clog2(SPACE_DEPTH + 1);
  localparam int OW = $clog2(csvfs_pkg::CMDQ_DEPTH + 2);

  logic          inside_r, inside_nxt;
  logic          qpend_r, qpend_nxt;
  logic          started_r, started_nxt;
  logic [CW-1:0] scnt_r, scnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          dropped_r, dropped_nxt;
  logic [OW-1:0] pend_flush_r, pend_flush_nxt;
  logic          accept, cont, eff_inside;

  // Hold off on a full queue, or while the back still reads an earlier flush
  assign in_full   = q_full || (pend_flush_r != '0);
  assign accept    = in_push && !in_full;
  assign ram_waddr = scnt_r[AW-1:0];
  assign ram_wdata = in_char_byte;

  always_comb begin
    inside_nxt  = inside_r;
    qpend_nxt   = qpend_r;
    started_nxt = started_r;
    scnt_nxt    = scnt_r;
    ovf_nxt     = ovf_r;
    dropped_nxt = dropped_r;
    q_push      = 1'b0;
    q_cmd       = '0;
    ram_we      = 1'b0;
    cont        = 1'b0;
    eff_inside  = inside_r && !qpend_r;

    if (accept) begin
      if (in_line_end) begin
        q_push        = 1'b1;
        q_cmd.marker  = 1'b1;
        q_cmd.row_end = 1'b1;
        q_cmd.ovf     = ovf_r;
        inside_nxt    = 1'b0;
        qpend_nxt     = 1'b0;
        started_nxt   = 1'b0;
        scnt_nxt      = '0;
        ovf_nxt       = 1'b0;
        dropped_nxt   = 1'b0;
      end else begin
        qpend_nxt = 1'b0;
        if (qpend_r && in_char_byte == csvfs_pkg::CH_QUOTE) begin
          cont = 1'b1;
        end else begin
          // a pending quote followed by anything else closes the quoting
          if (qpend_r) begin
            inside_nxt = 1'b0;
          end
          if (eff_inside) begin
            if (in_char_byte == csvfs_pkg::CH_QUOTE) begin
              qpend_nxt = 1'b1;
            end else begin
              cont = 1'b1;
            end
          end else if (in_char_byte == csvfs_pkg::CH_QUOTE) begin
            inside_nxt = 1'b1;
          end else if (in_char_byte == csvfs_pkg::CH_COMMA) begin
            q_push       = 1'b1;
            q_cmd.marker = 1'b1;
            q_cmd.ovf    = ovf_r;
            started_nxt  = 1'b0;
            scnt_nxt     = '0;
            ovf_nxt      = 1'b0;
            dropped_nxt  = 1'b0;
          end else begin
            cont = 1'b1;
          end
        end

        if (cont) begin
          if (csvfs_pkg::is_ws(in_char_byte)) begin
            // leading whitespace is dropped; inner runs wait in the buffer
            if (started_r) begin
              if (scnt_r < CW'(SPACE_DEPTH)) begin
                ram_we   = 1'b1;
                scnt_nxt = scnt_r + CW'(1);
              end else begin
                dropped_nxt = 1'b1;
              end
            end
          end else begin
            q_push      = 1'b1;
            q_cmd.data  = in_char_byte;
            q_cmd.flush = csvfs_pkg::CNT_W'(scnt_r);
            ovf_nxt     = ovf_r || dropped_r;
            scnt_nxt    = '0;
            dropped_nxt = 1'b0;
            started_nxt = 1'b1;
          end
        end
      end
    end

    pend_flush_nxt = pend_flush_r + OW'(q_push && (q_cmd.flush != '0)) - OW'(flush_done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r     <= 1'b0;
      qpend_r      <= 1'b0;
      started_r    <= 1'b0;
      scnt_r       <= '0;
      ovf_r        <= 1'b0;
      dropped_r    <= 1'b0;
      pend_flush_r <= '0;
    end else begin
      inside_r     <= inside_nxt;
      qpend_r      <= qpend_nxt;
      started_r    <= started_nxt;
      scnt_r       <= scnt_nxt;
      ovf_r        <= ovf_nxt;
      dropped_r    <= dropped_nxt;
      pend_flush_r <= pend_flush_nxt;
    end
  end

  `CSVFS_ASSERT_NOW(a_no_write_in_flush, clk, rst_n, ram_we, pend_flush_r == '0,
                    "space buffer written while a flush is outstanding")
  `CSVFS_ASSERT_NOW(a_scnt_bound, clk, rst_n, 1'b1, scnt_r <= CW'(SPACE_DEPTH),
                    "space count beyond buffer depth")
  `CSVFS_ASSERT_NXT(a_eol_clears, clk, rst_n, accept && in_line_end,
                    !inside_r && !qpend_r && !started_r && scnt_r == '0 && !ovf_r,
                    "line end did not return field state to rest")

endmodule

`default_nettype wire

// ----- rtl/core/csvfs_back.sv -----
// ---------------------------------------------------------------------------
// csvfs_back
// Executes queued commands: flushes buffered whitespace, emits bytes and
// markers into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "csv_field_splitter_trimmed_defines.svh"

module csvfs_back #(
  parameter int SPACE_DEPTH = csvfs_pkg::SPACE_DEPTH_DEF,
  parameter int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire csvfs_pkg::cmd_t q_cmd,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               flush_done,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  input  wire logic [7:0]    ram_rdata,
  output logic [7:0]         out_field_byte,
  output logic               out_has_byte,
  output logic               out_field_end,
  output logic               out_row_end,
  output logic               out_space_overflow,
  output logic               out_empty,
  input  wire logic          out_pop
);

  csvfs_pkg::back_state_t state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          valid_r, valid_nxt;
  logic          slot_free, load;
  logic [7:0]    ld_byte;
  logic          ld_has, ld_fend, ld_rend, ld_ovf;

  assign slot_free = !valid_r || out_pop;
  assign out_empty = !valid_r;
  assign ram_raddr = idx_r;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    flush_done = 1'b0;
    ram_re     = 1'b0;
    load       = 1'b0;
    ld_byte    = q_cmd.data;
    ld_has     = !q_cmd.marker;
    ld_fend    = q_cmd.marker;
    ld_rend    = q_cmd.row_end;
    ld_ovf     = q_cmd.ovf;

    case (state_r)
      csvfs_pkg::BK_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.marker || q_cmd.flush == '0) begin
            if (slot_free) begin
              load  = 1'b1;
              q_pop = 1'b1;
            end
          end else begin
            idx_nxt   = '0;
            state_nxt = csvfs_pkg::BK_READ;
          end
        end
      end
      csvfs_pkg::BK_READ: begin
        ram_re    = 1'b1;
        state_nxt = csvfs_pkg::BK_SEND;
      end
      csvfs_pkg::BK_SEND: begin
        ld_byte = ram_rdata;
        ld_has  = 1'b1;
        ld_fend = 1'b0;
        ld_rend = 1'b0;
        ld_ovf  = 1'b0;
        if (slot_free) begin
          load = 1'b1;
          if (csvfs_pkg::CNT_W'(idx_r) + csvfs_pkg::CNT_W'(1) == q_cmd.flush) begin
            state_nxt = csvfs_pkg::BK_LAST;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = csvfs_pkg::BK_READ;
          end
        end
      end
      csvfs_pkg::BK_LAST: begin
        if (slot_free) begin
          load       = 1'b1;
          q_pop      = 1'b1;
          flush_done = 1'b1;
          state_nxt  = csvfs_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = csvfs_pkg::BK_IDLE;
      end
    endcase

    valid_nxt = load || (valid_r && !out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csvfs_pkg::BK_IDLE;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_field_byte     <= ld_has ? ld_byte : 8'd0;
      out_has_byte       <= ld_has;
      out_field_end      <= ld_fend;
      out_row_end        <= ld_rend;
      out_space_overflow <= ld_ovf;
    end
  end

  `CSVFS_ASSERT_NOW(a_head_held, clk, rst_n, state_r != csvfs_pkg::BK_IDLE, !q_empty,
                    "flush in progress with no command at queue head")
  `CSVFS_ASSERT_NXT(a_read_then_send, clk, rst_n, state_r == csvfs_pkg::BK_READ,
                    state_r == csvfs_pkg::BK_SEND, "buffer read not followed by send")
  `CSVFS_ASSERT_NOW(a_done_on_last, clk, rst_n, flush_done,
                    state_r == csvfs_pkg::BK_LAST && q_pop,
                    "flush completion outside the final byte step")

endmodule

`default_nettype wire

// ----- rtl/core/csv_field_splitter_trimmed.sv -----
// CSV field splitter with whitespace trimming.
// Input channel: one line byte per word on in_char_byte, or an end-of-line
// word with in_line_end high; taken at a clock edge with in_push high and
// in_full low.
// Result channel: words of field content (out_has_byte high) and field
// markers (out_field_end high, out_row_end high on the last field of the
// line, out_space_overflow high when inner whitespace was dropped). The
// oldest word is shown while out_empty is low and leaves on out_pop.
// A word reaches the output register through the command queue. The block
// takes one input word per cycle, except that a content byte following N
// buffered whitespace bytes is handled in the back end as a start step, one
// buffer RAM read and one output load per flushed byte, then the byte
// itself; in_full stays high until that flush finishes.
// When the receiver stalls, the output register holds and the command queue
// fills, after which in_full rises. Reset empties the queue and output
// register and returns quoting and field state to rest; the whitespace buffer
// is not cleared, no flush reads an unwritten entry.
// ---------------------------------------------------------------------------
// csv_field_splitter_trimmed
// Top level: front end, command queue, whitespace buffer and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module csv_field_splitter_trimmed #(
  parameter int SPACE_DEPTH = csvfs_pkg::SPACE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_line_end,
  input  wire logic       in_push,
  output logic            in_full,
  output logic [7:0]      out_field_byte,
  output logic            out_has_byte,
  output logic            out_field_end,
  output logic            out_row_end,
  output logic            out_space_overflow,
  output logic            out_empty,
  input  wire logic       out_pop
);

  localparam int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

  csvfs_pkg::cmd_t push_cmd, head_cmd;
  logic            q_push, q_full, q_pop, q_empty, flush_done;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;

  csvfs_front #(
    .SPACE_DEPTH (SPACE_DEPTH),
    .AW          (AW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_char_byte (in_char_byte),
    .in_line_end  (in_line_end),
    .in_push      (in_push),
    .in_full      (in_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd),
    .q_full       (q_full),
    .flush_done   (flush_done),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata)
  );

  csvfs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (head_cmd),
    .empty (q_empty)
  );

  csvfs_ram #(
    .WIDTH (8),
    .DEPTH (SPACE_DEPTH),
    .AW    (AW)
  ) u_space_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  csvfs_back #(
    .SPACE_DEPTH (SPACE_DEPTH),
    .AW          (AW)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_cmd              (head_cmd),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .flush_done         (flush_done),
    .ram_re             (ram_re),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .out_field_byte     (out_field_byte),
    .out_has_byte       (out_has_byte),
    .out_field_end      (out_field_end),
    .out_row_end        (out_row_end),
    .out_space_overflow (out_space_overflow),
    .out_empty          (out_empty),
    .out_pop            (out_pop)
  );

endmodule

`default_nettype wire
